// File: rtl/core/fsd_pkg.sv
`default_nettype none
package fsd_pkg;

  // Default sizes of the line buffer and the frame counters.
  localparam int unsigned MAX_WIDTH_DEF  = 2048;
  localparam int unsigned MAX_HEIGHT_DEF = 4096;
  localparam int unsigned FRAC_BITS_DEF  = 8;

  // Pixel and configuration port widths.
  localparam int unsigned PIXEL_W     = 8;
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned CFG_DATA_W  = 13;
  localparam int unsigned WIDTH_REG_W = 12;
  localparam int unsigned HEIGHT_REG_W = 13;

  // Register indexes of the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;

  // Frame size after reset and the smallest sizes that are used.
  localparam int unsigned RESET_FRAME_WIDTH  = 640;
  localparam int unsigned RESET_FRAME_HEIGHT = 480;
  localparam int unsigned MIN_WIDTH          = 3;
  localparam int unsigned MIN_HEIGHT         = 2;

  // Quantizer levels in integer grey steps.
  localparam int unsigned THRESHOLD   = 127;
  localparam int unsigned WHITE_LEVEL = 255;

  // Diffusion weights in sixteenths.
  localparam int unsigned WEIGHT_RIGHT      = 7;
  localparam int unsigned WEIGHT_DOWN_LEFT  = 3;
  localparam int unsigned WEIGHT_DOWN       = 5;
  localparam int unsigned WEIGHT_DOWN_RIGHT = 1;
  localparam int unsigned WEIGHT_SHIFT      = 4;

  // Position flags of one pixel, worked out by the front end.
  typedef struct packed {
    logic first_col;
    logic first_row;
    logic eol;
    logic last_row;
  } fsd_flags_t;

endpackage
`default_nettype wire

// File: rtl/core/fsd_front.sv
`default_nettype none
module fsd_front #(
  parameter int unsigned MAX_WIDTH  = fsd_pkg::MAX_WIDTH_DEF,
  parameter int unsigned MAX_HEIGHT = fsd_pkg::MAX_HEIGHT_DEF,
  localparam int unsigned XW = $clog2(MAX_WIDTH),
  localparam int unsigned YW = $clog2(MAX_HEIGHT)
) (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  input  wire                              cfg_valid_i,
  output logic                             cfg_ready_o,
  input  wire  [fsd_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  wire  [fsd_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  input  wire                              in_valid_i,
  output logic                             in_ready_o,
  input  wire  [fsd_pkg::PIXEL_W-1:0]      pixel_in_i,
  output logic                             push_valid_o,
  input  wire                              push_ready_i,
  output logic [XW-1:0]                    push_x_o,
  output fsd_pkg::fsd_flags_t              push_flags_o,
  output logic [fsd_pkg::PIXEL_W-1:0]      push_pixel_o
);
  import fsd_pkg::*;

  // Clamps a size to its legal range and returns the index of its last element.
  function automatic int unsigned last_of(input int unsigned size, input int unsigned lo,
                                          input int unsigned hi);
    int unsigned s;
    s = size;
    if (s < lo) s = lo;
    if (s > hi) s = hi;
    return s - 1;
  endfunction

  logic [XW-1:0] col_q, col_d, last_col_q, x;
  logic [YW-1:0] row_q, row_d, last_row_q, y;
  logic          eol, last_row, accept;

  assign cfg_ready_o = 1'b1;

  // Counters past a shrunken size are taken as the last position.
  always_comb begin
    x        = (col_q > last_col_q) ? last_col_q : col_q;
    y        = (row_q > last_row_q) ? last_row_q : row_q;
    eol      = (x == last_col_q);
    last_row = (y == last_row_q);
    accept   = in_valid_i && push_ready_i;
    if (eol) begin
      col_d = '0;
      row_d = last_row ? '0 : y + 1'b1;
    end else begin
      col_d = x + 1'b1;
      row_d = y;
    end
  end

  // Classified item goes straight into the queue.
  assign in_ready_o             = push_ready_i;
  assign push_valid_o           = in_valid_i;
  assign push_x_o               = x;
  assign push_pixel_o           = pixel_in_i;
  assign push_flags_o.first_col = (x == '0);
  assign push_flags_o.first_row = (y == '0);
  assign push_flags_o.eol       = eol;
  assign push_flags_o.last_row  = last_row;

  // Position counters and the clamped frame size.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q      <= '0;
      row_q      <= '0;
      last_col_q <= XW'(last_of(RESET_FRAME_WIDTH, MIN_WIDTH, MAX_WIDTH));
      last_row_q <= YW'(last_of(RESET_FRAME_HEIGHT, MIN_HEIGHT, MAX_HEIGHT));
    end else begin
      if (accept) begin
        col_q <= col_d;
        row_q <= row_d;
      end
      if (cfg_valid_i) begin
        case (cfg_index_i)
          REG_FRAME_WIDTH: begin
            last_col_q <= XW'(last_of(int'(cfg_data_i[WIDTH_REG_W-1:0]), MIN_WIDTH,
                                      MAX_WIDTH));
          end
          REG_FRAME_HEIGHT: begin
            last_row_q <= YW'(last_of(int'(cfg_data_i[HEIGHT_REG_W-1:0]), MIN_HEIGHT,
                                      MAX_HEIGHT));
          end
          default: begin
          end
        endcase
      end
    end
  end

endmodule
`default_nettype wire

// File: rtl/core/fsd_queue.sv
`default_nettype none
module fsd_queue #(
  parameter int unsigned W = 8
) (
  input  wire          clk_i,
  input  wire          rst_ni,
  input  wire          push_valid_i,
  output logic         push_ready_o,
  input  wire  [W-1:0] push_data_i,
  output logic         pop_valid_o,
  input  wire          pop_ready_i,
  output logic [W-1:0] pop_data_o
);

  logic [W-1:0] entry_q [2];
  logic         wr_ptr_q, rd_ptr_q;
  logic [1:0]   count_q;
  logic         push, pop;

  assign push_ready_o = (count_q != 2'd2);
  assign pop_valid_o  = (count_q != 2'd0);
  assign pop_data_o   = entry_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_ptr_q] <= push_data_i;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= ~wr_ptr_q;
      if (pop) rd_ptr_q <= ~rd_ptr_q;
      if (push && !pop) begin
        count_q <= count_q + 2'd1;
      end else if (pop && !push) begin
        count_q <= count_q - 2'd1;
      end
    end
  end

endmodule
`default_nettype wire

// File: rtl/core/fsd_back.sv
`default_nettype none
module fsd_back #(
  parameter int unsigned MAX_WIDTH = fsd_pkg::MAX_WIDTH_DEF,
  parameter int unsigned FRAC_BITS = fsd_pkg::FRAC_BITS_DEF,
  localparam int unsigned XW = $clog2(MAX_WIDTH)
) (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          q_valid_i,
  output logic                         q_ready_o,
  input  wire  [XW-1:0]                q_x_i,
  input  fsd_pkg::fsd_flags_t          q_flags_i,
  input  wire  [fsd_pkg::PIXEL_W-1:0]  q_pixel_i,
  output logic                         out_valid_o,
  input  wire                          out_ready_i,
  output logic                         out_white_o,
  output logic                         end_of_line_o,
  output logic                         end_of_frame_o
);
  import fsd_pkg::*;

  // Error width, widened sum width and product width.
  localparam int unsigned EW = FRAC_BITS + 12;
  localparam int unsigned SW = EW + 2;
  localparam int unsigned PW = EW + 4;

  localparam logic signed [SW-1:0] SAT_HI = SW'((64'sd1 <<< (EW - 1)) - 64'sd1);
  localparam logic signed [SW-1:0] SAT_LO = SW'(-(64'sd1 <<< (EW - 1)));
  localparam logic signed [EW-1:0] THRESH = EW'(THRESHOLD << FRAC_BITS);
  localparam logic signed [SW-1:0] FULL_SCALE = SW'(WHITE_LEVEL << FRAC_BITS);
  localparam logic signed [PW-1:0] K_RIGHT = PW'(WEIGHT_RIGHT);
  localparam logic signed [PW-1:0] K_DL = PW'(WEIGHT_DOWN_LEFT);
  localparam logic signed [PW-1:0] K_DOWN = PW'(WEIGHT_DOWN);
  localparam logic signed [PW-1:0] K_DR = PW'(WEIGHT_DOWN_RIGHT);

  // Sign extension of an error value to the sum width.
  function automatic logic signed [SW-1:0] ext(input logic signed [EW-1:0] a);
    return $signed({{(SW - EW){a[EW-1]}}, a});
  endfunction

  // Saturation to the error range.
  function automatic logic signed [EW-1:0] sat(input logic signed [SW-1:0] v);
    logic signed [EW-1:0] r;
    if (v > SAT_HI) r = SAT_HI[EW-1:0];
    else if (v < SAT_LO) r = SAT_LO[EW-1:0];
    else r = v[EW-1:0];
    return r;
  endfunction

  // Floored share e * k / 16 of an error.
  function automatic logic signed [EW-1:0] part(input logic signed [EW-1:0] e,
                                                input logic signed [PW-1:0] k);
    logic signed [PW-1:0] p;
    logic signed [PW-1:0] s;
    p = $signed({{(PW - EW){e[EW-1]}}, e}) * k;
    s = p >>> WEIGHT_SHIFT;
    return s[EW-1:0];
  endfunction

  // Line buffer of errors for the next line.
  logic [EW-1:0] line_mem [MAX_WIDTH];
  logic [EW-1:0] rd_data_q;

  // Compute stage, carry loop, deferred write and output register.
  logic                  c_valid_q;
  logic [XW-1:0]         c_x_q;
  fsd_flags_t            c_flags_q;
  logic [PIXEL_W-1:0]    c_pixel_q;
  logic signed [EW-1:0]  rc_q, pl_q, pc_q;
  logic                  def_valid_q;
  logic [XW-1:0]         def_addr_q;
  logic [EW-1:0]         def_data_q;
  logic                  o_valid_q, o_white_q, o_eol_q, o_eof_q;

  logic                  c_adv, pop, main_we, wr_en, white, diffuse;
  logic [XW-1:0]         wr_addr;
  logic [EW-1:0]         wr_data;
  logic signed [EW-1:0]  above, carry, pl_eff, pc_eff, v, e;
  logic signed [EW-1:0]  rc_d, pl_d, pc_d, dl_val;
  logic signed [SW-1:0]  sum, pix_s, e_raw;

  // Handshake between queue, compute stage and output register.
  assign c_adv     = c_valid_q && (!o_valid_q || out_ready_i);
  assign q_ready_o = !c_valid_q || c_adv;
  assign pop       = q_valid_i && q_ready_o;

  // Quantizer and error split; the right carry closes the loop through the rc_q register.
  always_comb begin
    above   = c_flags_q.first_row ? '0 : $signed(rd_data_q);
    carry   = c_flags_q.first_col ? '0 : rc_q;
    pl_eff  = c_flags_q.first_col ? '0 : pl_q;
    pc_eff  = c_flags_q.first_col ? '0 : pc_q;
    pix_s   = $signed({{(SW - PIXEL_W - FRAC_BITS){1'b0}}, c_pixel_q, {FRAC_BITS{1'b0}}});
    sum     = pix_s + ext(above) + ext(carry);
    v       = sat(sum);
    white   = (v > THRESH);
    diffuse = !c_flags_q.last_row && !c_flags_q.first_col && !c_flags_q.eol;
    e_raw   = white ? ext(v) - FULL_SCALE : ext(v);
    e       = diffuse ? sat(e_raw) : '0;
    rc_d    = part(e, K_RIGHT);
    dl_val  = sat(ext(pl_eff) + ext(part(e, K_DL)));
    pl_d    = sat(ext(pc_eff) + ext(part(e, K_DOWN)));
    pc_d    = part(e, K_DR);
  end

  // One write port: the down-left write, or the deferred line-end write in the next cycle.
  always_comb begin
    main_we = c_adv && !c_flags_q.first_col;
    wr_en   = main_we || def_valid_q;
    if (main_we) begin
      wr_addr = c_x_q - 1'b1;
      wr_data = dl_val;
    end else begin
      wr_addr = def_addr_q;
      wr_data = def_data_q;
    end
  end

  // Line buffer ports; the read is issued as an item leaves the queue.
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      line_mem[wr_addr] <= wr_data;
    end
    if (pop) begin
      rd_data_q <= line_mem[q_x_i];
    end
  end

  // Payload of the compute stage, the deferred write and the output.
  always_ff @(posedge clk_i) begin
    if (pop) begin
      c_x_q     <= q_x_i;
      c_flags_q <= q_flags_i;
      c_pixel_q <= q_pixel_i;
    end
    if (c_adv) begin
      def_addr_q <= c_x_q;
      def_data_q <= pl_d;
      o_white_q  <= white;
      o_eol_q    <= c_flags_q.eol;
      o_eof_q    <= c_flags_q.eol && c_flags_q.last_row;
    end
  end

  // Valid flags and the diffusion state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_valid_q   <= 1'b0;
      o_valid_q   <= 1'b0;
      def_valid_q <= 1'b0;
      rc_q        <= '0;
      pl_q        <= '0;
      pc_q        <= '0;
    end else begin
      if (q_ready_o) c_valid_q <= q_valid_i;
      if (c_adv) begin
        o_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        o_valid_q <= 1'b0;
      end
      def_valid_q <= c_adv && c_flags_q.eol;
      if (c_adv) begin
        rc_q <= rc_d;
        pl_q <= pl_d;
        pc_q <= pc_d;
      end
    end
  end

  assign out_valid_o    = o_valid_q;
  assign out_white_o    = o_white_q;
  assign end_of_line_o  = o_eol_q;
  assign end_of_frame_o = o_eof_q;

endmodule
`default_nettype wire

// File: rtl/core/floyd_steinberg_dither_top.sv
// Path: an accepted item is written into the queue, moves into the compute stage and
// then into the output register; items ahead of it in the queue leave first.
// Throughput: one item per clock while out_ready_i holds, set by the back-end carry loop.
// Reset: counters, valid flags and diffusion state clear, frame size returns to 640x480;
// the line buffer is not cleared and line 0 of each frame ignores it.
`default_nettype none
module floyd_steinberg_dither_top #(
  parameter int unsigned MAX_WIDTH  = fsd_pkg::MAX_WIDTH_DEF,
  parameter int unsigned MAX_HEIGHT = fsd_pkg::MAX_HEIGHT_DEF,
  parameter int unsigned FRAC_BITS  = fsd_pkg::FRAC_BITS_DEF
) (
  input  wire                             clk_i,
  input  wire                             rst_ni,
  input  wire                             cfg_valid_i,
  output logic                            cfg_ready_o,
  input  wire  [fsd_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  wire  [fsd_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  input  wire                             in_valid_i,
  output logic                            in_ready_o,
  input  wire  [fsd_pkg::PIXEL_W-1:0]     pixel_in_i,
  output logic                            out_valid_o,
  input  wire                             out_ready_i,
  output logic                            out_white_o,
  output logic                            end_of_line_o,
  output logic                            end_of_frame_o
);
  import fsd_pkg::*;

  localparam int unsigned XW = $clog2(MAX_WIDTH);
  localparam int unsigned FW = $bits(fsd_flags_t);
  localparam int unsigned QW = XW + FW + PIXEL_W;

  logic               push_valid, push_ready, pop_valid, pop_ready;
  logic [XW-1:0]      push_x, pop_x;
  fsd_flags_t         push_flags, pop_flags;
  logic [PIXEL_W-1:0] push_pixel, pop_pixel;
  logic [QW-1:0]      push_data, pop_data;

  // Front end: counters, classification and configuration.
  fsd_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .pixel_in_i   (pixel_in_i),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_x_o     (push_x),
    .push_flags_o (push_flags),
    .push_pixel_o (push_pixel)
  );

  // Two-entry queue between front and back.
  assign push_data = {push_x, push_flags, push_pixel};
  assign pop_x     = pop_data[QW-1 -: XW];
  assign pop_flags = pop_data[PIXEL_W +: FW];
  assign pop_pixel = pop_data[PIXEL_W-1:0];

  fsd_queue #(
    .W (QW)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_data_i  (push_data),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_data_o   (pop_data)
  );

  // Back end: line buffer, quantizer and error diffusion.
  fsd_back #(
    .MAX_WIDTH (MAX_WIDTH),
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .q_valid_i      (pop_valid),
    .q_ready_o      (pop_ready),
    .q_x_i          (pop_x),
    .q_flags_i      (pop_flags),
    .q_pixel_i      (pop_pixel),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .out_white_o    (out_white_o),
    .end_of_line_o  (end_of_line_o),
    .end_of_frame_o (end_of_frame_o)
  );

endmodule
`default_nettype wire

// File: dv/tb_top.sv
`default_nettype none
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  // Sizes and fixed-point constants of the default build.
  localparam int unsigned LINE_MAX    = fsd_pkg::MAX_WIDTH_DEF;
  localparam int unsigned ROWS_MAX    = fsd_pkg::MAX_HEIGHT_DEF;
  localparam int unsigned FRAC        = fsd_pkg::FRAC_BITS_DEF;
  localparam longint      ERR_HI      = (longint'(1) <<< (FRAC + 11)) - 1;
  localparam longint      ERR_LO      = -ERR_HI - 1;
  localparam longint      UNIT        = longint'(1) <<< FRAC;
  localparam longint      LEVEL_MID   = longint'(fsd_pkg::THRESHOLD) * UNIT;
  localparam longint      LEVEL_WHITE = longint'(fsd_pkg::WHITE_LEVEL) * UNIT;
  localparam longint      K_RIGHT     = fsd_pkg::WEIGHT_RIGHT;
  localparam longint      K_DOWN_L    = fsd_pkg::WEIGHT_DOWN_LEFT;
  localparam longint      K_DOWN      = fsd_pkg::WEIGHT_DOWN;
  localparam longint      K_DOWN_R    = fsd_pkg::WEIGHT_DOWN_RIGHT;

  // An index that maps to no register; writes to it must be ignored.
  localparam logic [fsd_pkg::CFG_IDX_W-1:0] REG_SPARE = 2'd3;

  typedef logic [fsd_pkg::CFG_IDX_W-1:0]  cfg_idx_t;
  typedef logic [fsd_pkg::CFG_DATA_W-1:0] cfg_data_t;
  typedef logic [fsd_pkg::PIXEL_W-1:0]    pixel_t;

  typedef struct packed {
    logic white;
    logic eol;
    logic eof;
  } dot_t;

  // Error-diffusion predictor and the queue of dithered dots it expects.
  class halftone_checker;
    longint      row_err[LINE_MAX];
    bit          row_err_set[LINE_MAX];
    longint      carry_right;
    longint      sum_left;
    longint      sum_center;
    int unsigned col;
    int unsigned row;
    int unsigned width_reg;
    int unsigned height_reg;
    dot_t        expected_dots[$];
    int unsigned pixels;
    int unsigned dots;
    int unsigned lines;
    int unsigned frames;
    int unsigned errors;

    function new();
      carry_right = 0;
      sum_left    = 0;
      sum_center  = 0;
      col         = 0;
      row         = 0;
      width_reg   = fsd_pkg::RESET_FRAME_WIDTH;
      height_reg  = fsd_pkg::RESET_FRAME_HEIGHT;
      pixels      = 0;
      dots        = 0;
      lines       = 0;
      frames      = 0;
      errors      = 0;
    endfunction

    function longint clip(longint v);
      if (v > ERR_HI) return ERR_HI;
      if (v < ERR_LO) return ERR_LO;
      return v;
    endfunction

    // Weighted share of an error in sixteenths, rounded toward minus infinity.
    function longint share(longint e, longint k);
      return (e * k) >>> fsd_pkg::WEIGHT_SHIFT;
    endfunction

    function int unsigned line_len(int unsigned r);
      if (r < fsd_pkg::MIN_WIDTH) return fsd_pkg::MIN_WIDTH;
      if (r > LINE_MAX) return LINE_MAX;
      return r;
    endfunction

    // A wider line is only allowed where every line-buffer entry it reads was written.
    function bit width_ok(cfg_data_t data);
      int unsigned nw;
      nw = line_len(data[fsd_pkg::WIDTH_REG_W-1:0]);
      if (row == 0) return 1'b1;
      for (int unsigned i = 0; i < nw; i++) begin
        if (!row_err_set[i]) return 1'b0;
      end
      return 1'b1;
    endfunction

    function void write_reg(cfg_idx_t idx, cfg_data_t data);
      case (idx)
        fsd_pkg::REG_FRAME_WIDTH: begin
          width_reg = data[fsd_pkg::WIDTH_REG_W-1:0];
        end
        fsd_pkg::REG_FRAME_HEIGHT: begin
          height_reg = data[fsd_pkg::HEIGHT_REG_W-1:0];
        end
        default: begin
        end
      endcase
    endfunction

    // Threshold one pixel, spread its error and queue the expected dot.
    function void note_pixel(pixel_t p);
      int unsigned w;
      int unsigned h;
      int unsigned x;
      int unsigned y;
      bit          eol;
      bit          last;
      bit          spread;
      bit          white;
      longint      v;
      longint      e;
      longint      above;
      longint      carry;
      dot_t        d;
      w = line_len(width_reg);
      h = (height_reg < fsd_pkg::MIN_HEIGHT) ? fsd_pkg::MIN_HEIGHT :
          (height_reg > ROWS_MAX) ? ROWS_MAX : height_reg;
      // Counters left beyond a shrunken frame land on the last column or line.
      x = (col > w - 1) ? w - 1 : col;
      y = (row > h - 1) ? h - 1 : row;
      eol  = (x == w - 1);
      last = (y == h - 1);

      carry = 0;
      if (x == 0) begin
        carry_right = 0;
        sum_left    = 0;
        sum_center  = 0;
      end else begin
        carry = carry_right;
      end
      above = (y > 0) ? row_err[x] : 0;

      v      = clip(longint'(p) * UNIT + above + carry);
      white  = (v > LEVEL_MID);
      spread = !last && (x >= 1) && !eol;
      e      = spread ? clip(white ? v - LEVEL_WHITE : v) : 0;

      carry_right = share(e, K_RIGHT);
      if (x >= 1) begin
        row_err[x-1]     = clip(sum_left + share(e, K_DOWN_L));
        row_err_set[x-1] = 1'b1;
      end
      sum_left   = clip(sum_center + share(e, K_DOWN));
      sum_center = share(e, K_DOWN_R);
      if (eol) begin
        row_err[x]     = sum_left;
        row_err_set[x] = 1'b1;
      end

      if (eol) begin
        col = 0;
        row = last ? 0 : y + 1;
        lines++;
        if (last) frames++;
      end else begin
        col = x + 1;
        row = y;
      end

      pixels++;
      d.white = white;
      d.eol   = eol;
      d.eof   = eol && last;
      expected_dots.push_back(d);
    endfunction

    // Compare one dithered dot with the oldest expectation.
    function void check_dot(logic white, logic eol, logic eof);
      dot_t want;
      dots++;
      if (expected_dots.size() == 0) begin
        errors++;
        if (errors <= 10) begin
          $display("ERROR: dot with nothing expected: white=%0b eol=%0b eof=%0b",
                   white, eol, eof);
        end
        return;
      end
      want = expected_dots.pop_front();
      if (want.white !== white || want.eol !== eol || want.eof !== eof) begin
        errors++;
        if (errors <= 10) begin
          $display("ERROR: dot %0d expected white=%0b eol=%0b eof=%0b, got %0b %0b %0b",
                   dots, want.white, want.eol, want.eof, white, eol, eof);
        end
      end
    endfunction
  endclass

  logic      clk_i       = 1'b0;
  logic      rst_ni      = 1'b0;
  logic      cfg_valid_i = 1'b0;
  cfg_idx_t  cfg_index_i = '0;
  cfg_data_t cfg_data_i  = '0;
  logic      in_valid_i  = 1'b0;
  pixel_t    pixel_in_i  = '0;
  logic      out_ready_i = 1'b0;
  wire       cfg_ready_o;
  wire       in_ready_o;
  wire       out_valid_o;
  wire       out_white_o;
  wire       end_of_line_o;
  wire       end_of_frame_o;

  halftone_checker board;
  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;
  int          recv_hold     = 0;
  pixel_t      tone          = 8'd128;

  floyd_steinberg_dither_top uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .pixel_in_i     (pixel_in_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .out_white_o    (out_white_o),
    .end_of_line_o  (end_of_line_o),
    .end_of_frame_o (end_of_frame_o)
  );

  always #10 clk_i = ~clk_i;

  // Receiver: random stalls, or a long hold-off when one is requested.
  always @(negedge clk_i) begin
    if (recv_hold > 0) begin
      out_ready_i = 1'b0;
      recv_hold   = recv_hold - 1;
    end else begin
      out_ready_i = ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Check every dot the block hands over.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      board.check_dot(out_white_o, end_of_line_o, end_of_frame_o);
    end
  end

  // Offer one pixel, with an optional gap in front; entered and left at a falling edge.
  task automatic push_pixel(input pixel_t p);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid_i = 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    pixel_in_i = p;
    do @(posedge clk_i); while (!in_ready_o);
    board.note_pixel(p);
    @(negedge clk_i);
  endtask

  // Stop sending and wait until every expected dot has come out.
  task automatic settle();
    in_valid_i = 1'b0;
    while (board.expected_dots.size() != 0) @(posedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  // Write one register; the caller lowers the valid after its last write.
  task automatic cfg_write(input cfg_idx_t idx, input cfg_data_t data);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i  = data;
    do @(posedge clk_i); while (!cfg_ready_o);
    board.write_reg(idx, data);
    @(negedge clk_i);
  endtask

  // Mostly uniform grey, some extremes, and flat areas that build up error.
  function automatic pixel_t pick_pixel();
    int r;
    r = $urandom_range(99);
    if (r < 55) return pixel_t'($urandom_range(255));
    if (r < 70) begin
      case ($urandom_range(3))
        0: return 8'd0;
        1: return 8'd255;
        2: return 8'd127;
        default: return 8'd128;
      endcase
    end
    return tone ^ pixel_t'($urandom_range(1));
  endfunction

  // Pick a new frame size, out of range now and then; the block is idle here.
  task automatic retune();
    cfg_data_t w_data;
    cfg_data_t h_data;
    case ($urandom_range(9))
      0: w_data = cfg_data_t'($urandom_range(0, 2));
      1: w_data = cfg_data_t'($urandom_range(LINE_MAX, 4095));
      2: w_data = cfg_data_t'(fsd_pkg::MIN_WIDTH);
      default: w_data = cfg_data_t'($urandom_range(4, 24));
    endcase
    case ($urandom_range(9))
      0: h_data = cfg_data_t'($urandom_range(0, 1));
      1: h_data = cfg_data_t'($urandom_range(ROWS_MAX, 8191));
      2: h_data = cfg_data_t'(fsd_pkg::MIN_HEIGHT);
      default: h_data = cfg_data_t'($urandom_range(3, 7));
    endcase
    if ($urandom_range(3) != 0 && board.width_ok(w_data)) begin
      cfg_write(fsd_pkg::REG_FRAME_WIDTH, w_data);
    end
    if ($urandom_range(3) != 0) begin
      cfg_write(fsd_pkg::REG_FRAME_HEIGHT, h_data);
    end
    cfg_valid_i = 1'b0;
  endtask

  // Segments of random pixels, each under its own frame size.
  task automatic run_phase(input int sender_pct, input int receiver_pct, input int budget);
    int unsigned start;
    send_idle_pct = sender_pct;
    recv_idle_pct = receiver_pct;
    start = board.pixels;
    while (board.pixels - start < budget) begin
      retune();
      tone = pixel_t'($urandom_range(255));
      repeat ($urandom_range(20, 90)) push_pixel(pick_pixel());
      settle();
    end
  endtask

  initial begin
    board = new();
    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: thresholds and extremes at the reset size of 640x480.
    push_pixel(8'd0);
    push_pixel(8'd255);
    push_pixel(8'd127);
    push_pixel(8'd128);
    push_pixel(8'h55);
    push_pixel(8'hAA);
    settle();

    // Sizes below range clamp to 3x2; the column count is already past the new line end.
    cfg_write(fsd_pkg::REG_FRAME_WIDTH, 13'd1);
    cfg_write(fsd_pkg::REG_FRAME_HEIGHT, 13'd0);
    cfg_valid_i = 1'b0;
    push_pixel(8'd200);
    push_pixel(8'd60);
    push_pixel(8'd130);
    push_pixel(8'd255);
    settle();

    // Sizes above range clamp to the maximum; the spare index is ignored.
    cfg_write(REG_SPARE, 13'h1FFF);
    cfg_write(fsd_pkg::REG_FRAME_HEIGHT, 13'h1FFF);
    cfg_write(fsd_pkg::REG_FRAME_WIDTH, 13'hFFF);
    cfg_valid_i = 1'b0;
    push_pixel(8'd0);
    push_pixel(8'd255);
    push_pixel(8'd1);
    push_pixel(8'd254);
    push_pixel(8'd64);
    push_pixel(8'd192);
    push_pixel(8'd128);
    push_pixel(8'd127);
    settle();

    // Shrink the line mid-row, then shrink the frame while on line 2.
    cfg_write(fsd_pkg::REG_FRAME_WIDTH, 13'd3);
    cfg_valid_i = 1'b0;
    push_pixel(8'd90);
    push_pixel(8'd100);
    push_pixel(8'd140);
    push_pixel(8'd30);
    settle();
    cfg_write(fsd_pkg::REG_FRAME_HEIGHT, 13'd2);
    cfg_valid_i = 1'b0;
    push_pixel(8'd128);
    push_pixel(8'd128);
    push_pixel(8'd128);
    settle();

    run_phase(15, 52, 460);

    // Long receiver hold-off while the sender keeps offering: the block must stall.
    @(posedge clk_i);
    recv_hold = 300;
    @(negedge clk_i);
    repeat (80) push_pixel(pick_pixel());
    settle();

    // A few pixels at the largest frame where the line buffer allows the wider line,
    // then random sizes again.
    if (board.width_ok(cfg_data_t'(LINE_MAX))) begin
      cfg_write(fsd_pkg::REG_FRAME_WIDTH, cfg_data_t'(LINE_MAX));
    end
    cfg_write(fsd_pkg::REG_FRAME_HEIGHT, cfg_data_t'(ROWS_MAX));
    cfg_valid_i = 1'b0;
    repeat (60) push_pixel(pick_pixel());
    settle();
    run_phase(52, 15, 420);
    run_phase(0, 0, 420);

    settle();
    repeat (10) @(posedge clk_i);
    $display("Dithered %0d pixels over %0d line ends and %0d frame ends, sizes clamped both ways.",
             board.pixels, board.lines, board.frames);
    $display("Checked %0d dots: %0d wrong, %0d still awaited.",
             board.dots, board.errors, board.expected_dots.size());
    if (board.errors == 0 && board.expected_dots.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Watchdog far beyond the slowest correct run.
  initial begin
    #4_000_000;
    $display("Run stopped by the watchdog.");
    $display("end of test: mismatches");
    $finish;
  end

endmodule
`default_nettype wire
